// ===== rtl/fmn_pkg.sv =====
package fmn_pkg;

  // Default sizing of the frame store
  localparam int MAX_PIXELS_DEF = 65536;
  localparam int PIXEL_BITS_DEF = 16;

  // Fixed field widths
  localparam int IN_PIXEL_BITS = 16;
  localparam int GRAY_BITS     = 8;

  // Item kinds
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_DRAIN = 1'b1;

  // Controller to datapath commands
  typedef struct packed {
    logic load_en;
    logic drain_start;
    logic div_init;
    logic div_step;
    logic out_load;
  } fmn_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic drain_ok;
    logic out_free;
  } fmn_status_t;

endpackage

// ===== rtl/fmn_ctrl.sv =====
module fmn_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_kind,
  output logic              in_stall,
  input  fmn_pkg::fmn_status_t status,
  output fmn_pkg::fmn_cmd_t    cmd
);
  import fmn_pkg::*;

  localparam int SW = (GRAY_BITS > 1) ? $clog2(GRAY_BITS) : 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_INIT,
    ST_DIV,
    ST_DONE
  } state_t;

  state_t        state_r, state_nxt;
  logic [SW-1:0] step_r, step_nxt;
  logic          accept;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && (state_r == ST_IDLE);

  // Decode commands from state and the incoming transfer
  always_comb begin
    cmd             = '0;
    cmd.load_en     = accept && (in_kind == KIND_LOAD);
    cmd.drain_start = accept && (in_kind == KIND_DRAIN) && status.drain_ok;
    cmd.div_init    = (state_r == ST_INIT);
    cmd.div_step    = (state_r == ST_DIV);
    cmd.out_load    = (state_r == ST_DONE) && status.out_free;
  end

  // Sequence one drain: read, set up, eight quotient steps, hand off
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    case (state_r)
      ST_IDLE: begin
        if (cmd.drain_start) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        state_nxt = ST_INIT;
      end
      ST_INIT: begin
        step_nxt  = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        step_nxt = step_r + SW'(1);
        if (step_r == SW'(GRAY_BITS - 1)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (status.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

endmodule

// ===== rtl/fmn_dp.sv =====
module fmn_dp #(
  parameter int MAX_PIXELS = fmn_pkg::MAX_PIXELS_DEF,
  parameter int PIXEL_BITS = fmn_pkg::PIXEL_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [fmn_pkg::IN_PIXEL_BITS-1:0]   in_pixel_value,
  input  logic                                in_frame_end,
  input  fmn_pkg::fmn_cmd_t                   cmd,
  output fmn_pkg::fmn_status_t                status,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [fmn_pkg::GRAY_BITS-1:0]       out_gray_value,
  output logic                                out_zero_max_error,
  output logic                                out_last_pixel
);
  import fmn_pkg::*;

  localparam int AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int CW = $clog2(MAX_PIXELS + 1);
  localparam int PW = PIXEL_BITS + GRAY_BITS;

  logic [PIXEL_BITS-1:0] mem [MAX_PIXELS];

  logic [PIXEL_BITS-1:0] max_r;
  logic [CW-1:0]         count_r;
  logic [CW-1:0]         rp_r;
  logic                  done_r;

  logic [PIXEL_BITS-1:0] rd_data_r;
  logic                  last_r;
  logic [PIXEL_BITS-1:0] rem_r;
  logic [GRAY_BITS-1:0]  nlo_r;
  logic [GRAY_BITS-1:0]  quo_r;

  logic                  out_valid_r;
  logic [GRAY_BITS-1:0]  gray_r;
  logic                  err_r;
  logic                  olast_r;

  logic [PIXEL_BITS-1:0] pix;
  logic [PIXEL_BITS-1:0] max_b;
  logic [CW-1:0]         count_b;
  logic                  room;
  logic [CW-1:0]         rp_inc;
  logic [PW-1:0]         prod;
  logic [PIXEL_BITS:0]   trial;
  logic                  fits;

  assign pix     = in_pixel_value[PIXEL_BITS-1:0];
  assign max_b   = done_r ? '0 : max_r;
  assign count_b = done_r ? '0 : count_r;
  assign room    = (count_b < CW'(MAX_PIXELS));
  assign rp_inc  = rp_r + CW'(1);

  assign status.drain_ok = done_r && (rp_r < count_r);
  assign status.out_free = !out_valid_r || !out_stall;

  // 255 * pixel as (pixel << 8) - pixel
  assign prod  = {rd_data_r, {GRAY_BITS{1'b0}}} - {{GRAY_BITS{1'b0}}, rd_data_r};
  // One restoring-division step: shift in the next numerator bit, try subtract
  assign trial = {rem_r, nlo_r[GRAY_BITS-1]};
  assign fits  = (trial >= {1'b0, max_r});

  // Frame store write and registered read
  always_ff @(posedge clk) begin
    if (cmd.load_en && room) begin
      mem[count_b[AW-1:0]] <= pix;
    end
    if (cmd.drain_start) begin
      rd_data_r <= mem[rp_r[AW-1:0]];
    end
  end

  // Frame bookkeeping: restart on a load after a closed frame
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r   <= '0;
      count_r <= '0;
      rp_r    <= '0;
      done_r  <= 1'b0;
    end else if (cmd.load_en) begin
      done_r <= in_frame_end;
      if (done_r) begin
        rp_r <= '0;
      end
      if (room) begin
        count_r <= count_b + CW'(1);
        max_r   <= (pix > max_b) ? pix : max_b;
      end else begin
        count_r <= count_b;
        max_r   <= max_b;
      end
    end else if (cmd.drain_start) begin
      rp_r <= rp_inc;
    end
  end

  // Divider: capture last flag, set up, then one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (cmd.drain_start) begin
      last_r <= (rp_inc == count_r);
    end
    if (cmd.div_init) begin
      rem_r <= prod[PW-1:GRAY_BITS];
      nlo_r <= prod[GRAY_BITS-1:0];
    end else if (cmd.div_step) begin
      rem_r <= fits ? PIXEL_BITS'(trial - {1'b0, max_r}) : trial[PIXEL_BITS-1:0];
      nlo_r <= {nlo_r[GRAY_BITS-2:0], 1'b0};
      quo_r <= {quo_r[GRAY_BITS-2:0], fits};
    end
  end

  // Output register: hold until the transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      gray_r  <= (max_r == '0) ? '0 : quo_r;
      err_r   <= (max_r == '0);
      olast_r <= last_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_gray_value     = gray_r;
  assign out_zero_max_error = err_r;
  assign out_last_pixel     = olast_r;

endmodule

// ===== rtl/frame_max_normalize_16_to_8.sv =====
// Frame maximum normalization, 16-bit monochrome to 8-bit gray. Load items
// (kind 0) write pixels into an on-chip frame store of MAX_PIXELS entries and
// track the frame maximum; frame_end on a load closes the frame, and the next
// load starts a new one. Drain items (kind 1) read the stored pixels back in
// order and return floor(255*pixel/max) with last_pixel on the final one; a
// zero maximum returns 0 with zero_max_error set. Loads, dropped drains and
// loads beyond a full store give no result and leave the input free for the
// next item. An accepted drain holds the input through one frame store read,
// one setup step for 255*pixel, eight steps of the bit-per-cycle restoring
// divider and one hand-off into the output register. A result waiting
// in the output register does not block the next load; a following drain
// waits only if the previous result is still held at its hand-off.
module frame_max_normalize_16_to_8 #(
  parameter int MAX_PIXELS = fmn_pkg::MAX_PIXELS_DEF,
  parameter int PIXEL_BITS = fmn_pkg::PIXEL_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_kind,
  input  logic [fmn_pkg::IN_PIXEL_BITS-1:0] in_pixel_value,
  input  logic                              in_frame_end,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [fmn_pkg::GRAY_BITS-1:0]     out_gray_value,
  output logic                              out_zero_max_error,
  output logic                              out_last_pixel
);
  import fmn_pkg::*;

  fmn_cmd_t    cmd;
  fmn_status_t status;

  fmn_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_kind  (in_kind),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  fmn_dp #(
    .MAX_PIXELS (MAX_PIXELS),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_pixel_value     (in_pixel_value),
    .in_frame_end       (in_frame_end),
    .cmd                (cmd),
    .status             (status),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_gray_value     (out_gray_value),
    .out_zero_max_error (out_zero_max_error),
    .out_last_pixel     (out_last_pixel)
  );

endmodule
